@@ rtl/fsm_pkg.sv @@
package fsm_pkg;

    localparam int MAX_JOBS     = 64;
    localparam int MAX_MACHINES = 32;
    localparam int TIME_BITS    = 16;

    localparam int JOB_W  = $clog2(MAX_JOBS);
    localparam int MACH_W = $clog2(MAX_MACHINES);
    localparam int CFG_W  = 6;
    localparam int CT_W   = 32;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_SCHED = 2'd2;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [5:0]           job_index;
        logic [4:0]           machine_index;
        logic [TIME_BITS-1:0] proc_time;
    } t_in;

    typedef struct packed {
        logic [CT_W-1:0] makespan;
        logic            saturated;
    } t_out;

    // controls shared by every cell of the row
    typedef struct packed {
        logic                 clear;
        logic                 rd_en;
        logic [JOB_W-1:0]     rd_addr;
        logic                 wr_en;
        logic [JOB_W-1:0]     wr_addr;
        logic [TIME_BITS-1:0] wr_data;
    } t_cell_ctl;

endpackage

@@ rtl/fsm_cell.sv @@
module fsm_cell
    import fsm_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cell_ctl       i_ctl,
    input  logic            i_wr_sel,
    input  logic            i_active,
    input  logic            i_tok,
    input  logic [CT_W-1:0] i_left,
    output logic            o_tok,
    output logic [CT_W-1:0] o_ctime,
    output logic            o_clip
);

    // this machine's column of the processing time table
    logic [TIME_BITS-1:0] r_mem [MAX_JOBS];
    logic [TIME_BITS-1:0] r_time;
    logic [CT_W-1:0]      r_ctime;
    logic [CT_W-1:0]      n_ctime;
    logic                 r_tok;
    logic [CT_W-1:0]      w_start;
    logic [CT_W:0]        w_sum;
    logic                 w_upd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && i_wr_sel) begin
            r_mem[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
        if (i_ctl.rd_en) begin
            r_time <= r_mem[i_ctl.rd_addr];
        end
    end

    always_comb begin
        w_start = (r_ctime > i_left) ? r_ctime : i_left;
        w_sum   = {1'b0, w_start} + (CT_W+1)'(r_time);
        w_upd   = i_tok && i_active;
        n_ctime = r_ctime;
        if (i_ctl.clear) begin
            n_ctime = '0;
        end else if (w_upd) begin
            n_ctime = w_sum[CT_W] ? '1 : w_sum[CT_W-1:0];
        end
    end

    // token stops at the first machine out of use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctime <= '0;
            r_tok   <= 1'b0;
        end else begin
            r_ctime <= n_ctime;
            r_tok   <= i_tok && i_active;
        end
    end

    assign o_tok   = r_tok;
    assign o_ctime = r_ctime;
    assign o_clip  = w_upd && w_sum[CT_W];

endmodule

@@ rtl/flow_shop_makespan.sv @@
// permutation flow shop makespan evaluator
// input channel: i_in_valid / o_in_stall with a t_in payload; a transfer is taken
// when valid is high and stall low. one item is worked at a time, stall is high
// while an item is in flight
// output channel: o_out_valid / i_out_stall with a t_out payload held in an output
// register, so the next item is taken while a result still waits
// configuration: i_cfg_valid / o_cfg_ready writes machine_count, taken when idle
// sequencing: write, clear and unused opcodes go to the finish state, which loads
// the output register, and the input stays stalled until then; a schedule over m
// machines in use (1 to 32) first reads the table into a register, then a token
// walks the row of machine cells, one cell per cycle
// reset: completion row and clip flag cleared, machine_count 1; the time table is
// not cleared and holds nothing defined until written
// a stalled receiver holds the finished result; a later item waits in its final
// cycle until the output register frees
module flow_shop_makespan
    import fsm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out             o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RIPPLE = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [MACH_W-1:0] r_cnt, n_cnt;
    logic [CFG_W-1:0]  r_mcount;
    logic              r_clip, n_clip;
    logic              r_out_valid;
    t_out              r_out;

    logic              w_accept;
    logic              w_load;
    logic              w_start;
    logic [MACH_W-1:0] w_last;
    t_cell_ctl         w_ctl;

    logic              w_tok   [MAX_MACHINES+1];
    logic [CT_W-1:0]   w_ctime [MAX_MACHINES];
    logic [MAX_MACHINES-1:0] w_clip;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);

    // last machine in use, count clamped into 1..MAX_MACHINES
    always_comb begin
        if (r_mcount == '0) begin
            w_last = '0;
        end else if (r_mcount > CFG_W'(MAX_MACHINES)) begin
            w_last = MACH_W'(MAX_MACHINES - 1);
        end else begin
            w_last = MACH_W'(r_mcount - CFG_W'(1));
        end
    end

    // shared cell controls, all taken straight from the accepted transfer
    always_comb begin
        w_ctl.clear   = w_accept && (i_in_data.opcode == OP_CLEAR);
        w_ctl.rd_en   = w_accept && (i_in_data.opcode == OP_SCHED);
        w_ctl.rd_addr = JOB_W'(i_in_data.job_index);
        w_ctl.wr_en   = w_accept && (i_in_data.opcode == OP_WRITE);
        w_ctl.wr_addr = JOB_W'(i_in_data.job_index);
        w_ctl.wr_data = i_in_data.proc_time;
    end

    // token enters machine 0 in the first ripple cycle
    assign w_start  = (r_state == ST_RIPPLE) && (r_cnt == '0);
    assign w_tok[0] = w_start;

    genvar k;
    generate
        for (k = 0; k < MAX_MACHINES; k++) begin : g_cell
            logic [CT_W-1:0] w_left;
            if (k == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_rest
                assign w_left = w_ctime[k-1];
            end
            fsm_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_wr_sel (i_in_data.machine_index == MACH_W'(k)),
                .i_active (MACH_W'(k) <= w_last),
                .i_tok    (w_tok[k]),
                .i_left   (w_left),
                .o_tok    (w_tok[k+1]),
                .o_ctime  (w_ctime[k]),
                .o_clip   (w_clip[k])
            );
        end
    endgenerate

    // result register is free when empty or taken this cycle
    assign w_load = (r_state == ST_FINISH) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (w_accept) begin
                    n_state = (i_in_data.opcode == OP_SCHED) ? ST_RIPPLE : ST_FINISH;
                end
            end
            ST_RIPPLE: begin
                if (r_cnt == w_last) begin
                    n_state = ST_FINISH;
                end else begin
                    n_cnt = r_cnt + MACH_W'(1);
                end
            end
            ST_FINISH: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sticky clip flag, cleared only by a clear or reset
    always_comb begin
        n_clip = r_clip;
        if (w_ctl.clear) begin
            n_clip = 1'b0;
        end else if (|w_clip) begin
            n_clip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_mcount    <= CFG_W'(1);
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_clip  <= n_clip;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mcount <= i_cfg_data;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.makespan  <= w_ctime[w_last];
            r_out.saturated <= r_clip;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_clear_drops_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.clear |=> !r_clip)
        else $error("clip flag survived a clear");

    a_clip_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clip && !w_ctl.clear |=> r_clip)
        else $error("clip flag dropped without a clear");

    a_ripple_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RIPPLE) && (r_cnt == w_last) |=> (r_state == ST_FINISH))
        else $error("ripple did not finish at last machine");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ST_IDLE))
        else $error("accepted transfer left block idle");
`endif

endmodule
